// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another one in the same cycle
`define CHK_IMPLY(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("lbl failed");

// Check that a condition implies another one in the next cycle
`define CHK_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("lbl failed");

`endif

// ===== hdl/dog_pkg.sv =====
// Package with types and constants of the difference of Gaussians filter
package dog_pkg;
  localparam int unsigned REG_IDX_W = 3;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_KSIZE  = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_THRESH = 3'd3,
    REG_F_LO   = 3'd4,
    REG_F_HI   = 3'd5,
    REG_S_LO   = 3'd6,
    REG_S_HI   = 3'd7
  } reg_idx_t;

  localparam int unsigned CFG_W = 64;
  localparam logic [7:0] PIX_MAX = 8'd255;
  localparam int unsigned GAIN = 20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_CLAMP,
    ST_OUT
  } state_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
endpackage

// ===== hdl/difference_of_gaussians_filter.sv =====
// Top level of the difference of Gaussians filter
// One word is taken at a time. A word that makes an output ready runs a
// window scan over one synchronous line store port, one window pixel per
// cycle. From one accepted word to the next, the steps are: write the pixel
// and decide, the scan (skipped for kernel size zero), drain the accumulate
// pipe, clamp, hand off the output and accept the next word. The hand-off
// waits while out_ready stays low. Words that release no output only write
// the pixel and decide before the next word is accepted. No clearing pass.
module difference_of_gaussians_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_TAPS   = 7,
  parameter int STORE_ROWS = 8,
  parameter int TAP_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [dog_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [dog_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic [7:0]                in_pixel,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_out_value,
  output logic                      out_row_end,
  output logic                      out_frame_end
);
  import dog_pkg::*;
`include "assert_macros.svh"

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(STORE_ROWS);
  localparam int AW = RW + CW;
  localparam int DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int KW = $clog2(MAX_TAPS + 1);
  localparam int WB = 2 * TAP_BITS;
  localparam int SW = WB + 8 + 2 * KW + 2;
  localparam int NT = (7 < MAX_TAPS) ? 7 : MAX_TAPS;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic mem_we;

  logic [2:0]  ksize_r;
  logic [10:0] width_r;
  logic [11:0] height_r;
  logic signed [8:0] thresh_r;
  logic [63:0] f_lo_r, s_lo_r;
  logic [47:0] f_hi_r, s_hi_r;

  logic [CW:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [12:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [KW-1:0] ii_r, ii_nxt, jj_r, jj_nxt, ri_r, rj_r;
  logic rv_r, rv_nxt;
  logic rv1_r;
  logic pipe_busy;
  logic op_valid_r;
  logic [SW-1:0] s1_r, s1_nxt, s2_r, s2_nxt;
  logic [WB-1:0] w1_r, w2_r;
  logic [7:0] pix_r;
  logic [7:0] res_r, res_nxt;
  logic re_r, re_nxt, fe_r, fe_nxt;
  logic op_r;
  logic [7:0] pin_r;
  state_t st_r, st_nxt;

  logic [CW:0] w_eff;
  logic [12:0] h_eff;
  logic [KW-1:0] ks, half;

  always_comb begin
    if (width_r == 11'd0) w_eff = (CW+1)'(1);
    else if (32'(width_r) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(width_r);
    h_eff = (height_r == 12'd0) ? 13'd1 : {1'b0, height_r};
    ks = (32'(ksize_r) > MAX_TAPS) ? KW'(MAX_TAPS) : KW'(ksize_r);
    half = ks >> 1;
  end

  function automatic logic [TAP_BITS-1:0] get_tap(input logic [63:0] lo,
                                                  input logic [47:0] hi,
                                                  input logic [KW-1:0] k);
    logic [63:0] sh;
    logic [TAP_BITS-1:0] t;
    t = '0;
    if (32'(k) < 4) begin
      sh = lo >> (32'(k) * TAP_BITS);
      if (32'(k) * TAP_BITS < 64) t = sh[TAP_BITS-1:0];
    end else if (32'(k) < NT) begin
      sh = {16'd0, hi} >> ((32'(k) - 4) * TAP_BITS);
      if ((32'(k) - 4) * TAP_BITS < 64) t = sh[TAP_BITS-1:0];
    end
    return t;
  endfunction

  // window coordinate with border replication
  logic signed [14:0] iy_s, ix_s;
  logic [12:0] iy;
  logic [CW:0] ix;
  always_comb begin
    iy_s = $signed({2'b00, out_row_r}) + $signed(15'(ii_r)) - $signed(15'(half));
    ix_s = $signed(15'(out_col_r)) + $signed(15'(jj_r)) - $signed(15'(half));
    if (iy_s < 0) iy = '0;
    else if (iy_s > $signed(15'(h_eff) - 15'sd1)) iy = h_eff - 13'd1;
    else iy = iy_s[12:0];
    if (ix_s < 0) ix = '0;
    else if (ix_s > $signed(15'(w_eff) - 15'sd1)) ix = w_eff - (CW+1)'(1);
    else ix = ix_s[CW:0];
    rd_addr = {iy[RW-1:0], ix[CW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= pin_r;
    rd_q <= mem[rd_addr];
  end

  // ready decision for the word being handled
  logic stored, ready_c;
  logic [12:0] req_row;
  logic [CW:0] req_col;
  always_comb begin
    stored = (op_r == OP_PIXEL) && (in_row_r < h_eff);
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (stored) begin
      in_col_nxt = in_col_r + 1'b1;
      if (in_col_nxt >= w_eff) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 13'd1;
      end
    end
    req_row = out_row_r + 13'(half);
    if (req_row > h_eff - 13'd1) req_row = h_eff - 13'd1;
    req_col = out_col_r + (CW+1)'(half);
    if (req_col > w_eff - (CW+1)'(1)) req_col = w_eff - (CW+1)'(1);
    ready_c = (out_row_r < h_eff) && ((in_row_nxt >= h_eff) || (in_row_nxt > req_row) ||
              ((in_row_nxt == req_row) && (in_col_nxt > req_col)));
    wr_addr = {in_row_r[RW-1:0], in_col_r[CW-1:0]};
    mem_we = (st_r == ST_IDLE) && op_valid_r && stored;
  end

  logic last_tap;
  assign last_tap = (ii_r == ks - KW'(1)) && (jj_r == ks - KW'(1));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (op_valid_r) st_nxt = (ready_c && ks != '0) ? ST_SCAN :
                                          (ready_c ? ST_FINISH : ST_IDLE);
      ST_SCAN:   if (last_tap) st_nxt = ST_FINISH;
      ST_FINISH: if (!pipe_busy) st_nxt = ST_CLAMP;
      ST_CLAMP:  st_nxt = ST_OUT;
      ST_OUT:    if (out_ready) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // clamp and combine
  localparam logic [SW-1:0] TOP = SW'(255) << WB;
  logic [SW-1:0] a_c, b_c;
  logic signed [SW+6:0] v_c;
  logic [7:0] val_c;
  always_comb begin
    a_c = (s1_r > TOP) ? TOP : s1_r;
    b_c = (s2_r > TOP) ? TOP : s2_r;
    v_c = $signed((SW+7)'(TOP)) - (SW+7)'(GAIN) * ($signed((SW+7)'(b_c)) -
          $signed((SW+7)'(a_c)));
    if (v_c < 0) val_c = 8'd0;
    else if (v_c > $signed((SW+7)'(TOP))) val_c = PIX_MAX;
    else val_c = v_c[WB+7:WB];
    if (thresh_r >= 0) val_c = ($signed({1'b0, val_c}) >= thresh_r) ? PIX_MAX : 8'd0;
  end

  always_comb begin
    ii_nxt = ii_r;
    jj_nxt = jj_r;
    rv_nxt = 1'b0;
    s1_nxt = s1_r;
    s2_nxt = s2_r;
    res_nxt = res_r;
    re_nxt = re_r;
    fe_nxt = fe_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (st_r == ST_IDLE) begin
      ii_nxt = '0;
      jj_nxt = '0;
      s1_nxt = '0;
      s2_nxt = '0;
    end
    if (st_r == ST_SCAN) begin
      rv_nxt = 1'b1;
      if (jj_r == ks - KW'(1)) begin
        jj_nxt = '0;
        ii_nxt = ii_r + KW'(1);
      end else begin
        jj_nxt = jj_r + KW'(1);
      end
    end
    if (rv_r) begin
      s1_nxt = s1_r + SW'(pix_r) * SW'(w1_r);
      s2_nxt = s2_r + SW'(pix_r) * SW'(w2_r);
    end
    if (st_r == ST_CLAMP) begin
      res_nxt = val_c;
      re_nxt = (out_col_r == w_eff - (CW+1)'(1));
      fe_nxt = re_nxt && (out_row_r == h_eff - 13'd1);
    end
    if (st_r == ST_OUT && out_ready) begin
      out_col_nxt = out_col_r + 1'b1;
      if (out_col_nxt >= w_eff) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 13'd1;
      end
    end
  end

  // weights for the registered pixel, one stage behind the address
  logic [TAP_BITS-1:0] fa, fb, sa, sb;
  always_comb begin
    fa = get_tap(f_lo_r, f_hi_r, ri_r);
    fb = get_tap(f_lo_r, f_hi_r, rj_r);
    sa = get_tap(s_lo_r, s_hi_r, ri_r);
    sb = get_tap(s_lo_r, s_hi_r, rj_r);
  end

  always_ff @(posedge clk) begin
    ri_r <= ii_r;
    rj_r <= jj_r;
    w1_r <= WB'(fa) * WB'(fb);
    w2_r <= WB'(sa) * WB'(sb);
    pix_r <= rd_q;
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    res_r <= res_nxt;
    re_r <= re_nxt;
    fe_r <= fe_nxt;
    ii_r <= ii_nxt;
    jj_r <= jj_nxt;
    if (in_valid && in_ready) begin
      op_r <= in_op;
      pin_r <= in_pixel;
    end
  end

  // the pixel passes rd_q and pix_r and the weights pass ri_r and w1_r, so rv passes rv1_r and rv_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      rv1_r <= 1'b0;
      rv_r <= 1'b0;
      op_valid_r <= 1'b0;
      in_col_r <= '0;
      in_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      ksize_r <= 3'd5;
      width_r <= 11'd640;
      height_r <= 12'd480;
      thresh_r <= -9'sd1;
      f_lo_r <= '0;
      f_hi_r <= '0;
      s_lo_r <= '0;
      s_hi_r <= '0;
    end else begin
      st_r <= st_nxt;
      rv1_r <= rv_nxt;
      rv_r <= rv1_r;
      op_valid_r <= in_valid && in_ready;
      if ((cfg_we && (cfg_index == REG_KSIZE || cfg_index == REG_WIDTH ||
                      cfg_index == REG_HEIGHT)) ||
          (st_r == ST_OUT && out_ready && fe_r)) begin
        in_col_r <= '0;
        in_row_r <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        if (st_r == ST_IDLE && op_valid_r) begin
          in_col_r <= in_col_nxt;
          in_row_r <= in_row_nxt;
        end
        out_col_r <= out_col_nxt;
        out_row_r <= out_row_nxt;
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_KSIZE:  ksize_r <= cfg_data[2:0];
          REG_WIDTH:  width_r <= cfg_data[10:0];
          REG_HEIGHT: height_r <= cfg_data[11:0];
          REG_THRESH: thresh_r <= $signed(cfg_data[8:0]);
          REG_F_LO:   f_lo_r <= cfg_data;
          REG_F_HI:   f_hi_r <= cfg_data[47:0];
          REG_S_LO:   s_lo_r <= cfg_data;
          REG_S_HI:   s_hi_r <= cfg_data[47:0];
          default: ;
        endcase
      end
    end
  end

  // finish waits for the accumulate pipe to empty
  assign pipe_busy = rv1_r || rv_r;

  assign in_ready = (st_r == ST_IDLE) && !op_valid_r;
  assign out_valid = (st_r == ST_OUT);
  assign out_out_value = res_r;
  assign out_row_end = re_r;
  assign out_frame_end = fe_r;

  `CHK_IMPLY(a_ready_idle, clk, rst_n, in_ready, st_r == ST_IDLE)
  `CHK_IMPLY(a_fe_re, clk, rst_n, out_valid && out_frame_end, out_row_end)
  `CHK_NEXT(a_out_done, clk, rst_n, out_valid && out_ready, !out_valid)
  `CHK_IMPLY(a_pipe, clk, rst_n, st_r == ST_CLAMP, !pipe_busy)
endmodule
